FILE: sv/gmhp_pkg.sv
// gmhp_pkg: types, codes and character constants shared by the response header parser,
// its parse stage, result queue and port checker. Depends on nothing.
package gmhp_pkg;

  localparam int MAX_RES  = 3;
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;
  localparam int RQ_CNT_W = 3;
  localparam int HDR_CNT_W = 11;

  localparam logic [HDR_CNT_W-1:0] HDR_CNT_MAX = 11'd2047;
  localparam logic [HDR_CNT_W-1:0] HDR_MIN_POS = 11'd3;
  localparam logic [HDR_CNT_W-1:0] HDR_CR_META = 11'd4;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [3:0] DIGIT_SUCCESS  = 4'd2;
  localparam logic [3:0] DIGIT_REDIRECT = 4'd3;
  localparam logic [3:0] DIGIT_TEMP     = 4'd4;
  localparam logic [3:0] DIGIT_PERM     = 4'd5;
  localparam logic [3:0] DIGIT_AUTH     = 4'd6;

  typedef enum logic [0:0] {
    OP_DATA  = 1'b0,
    OP_CLOSE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    KIND_META   = 3'd0,
    KIND_BODY   = 3'd1,
    KIND_ACCEPT = 3'd2,
    KIND_FAIL   = 3'd3,
    KIND_FINISH = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_PROTOCOL    = 3'd1,
    ERR_UNAVAILABLE = 3'd2,
    ERR_NOT_FOUND   = 3'd3,
    ERR_AUTH        = 3'd4,
    ERR_UNSUPPORTED = 3'd5,
    ERR_CLOSED      = 3'd6
  } err_t;

  typedef enum logic [2:0] {
    PH_PENDING  = 3'd0,
    PH_BODY     = 3'd1,
    PH_REDIRECT = 3'd2,
    PH_FAILED   = 3'd3,
    PH_DONE     = 3'd4
  } phase_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    kind_t      result_kind;
    logic [7:0] out_byte;
    logic [3:0] status_first;
    logic [3:0] status_second;
    err_t       error_code;
    logic       last;
  } out_item_t;

  function automatic out_item_t mk_byte(kind_t kind, logic [7:0] b);
    out_item_t r;
    r = '0;
    r.result_kind = kind;
    r.out_byte    = b;
    return r;
  endfunction

  function automatic out_item_t mk_fail(err_t code);
    out_item_t r;
    r = '0;
    r.result_kind = KIND_FAIL;
    r.error_code  = code;
    return r;
  endfunction

endpackage

FILE: sv/gemini_response_header_parser.sv
// gemini_response_header_parser: top level, mode register, parse stage and result queue.
// Depends on gmhp_pkg, gmhp_parse and gmhp_rq.
//
//   channel  direction  handshake            payload
//   in_      request    in_valid / in_stall  gmhp_pkg::in_item_t
//   out_     result     out_valid/out_stall  gmhp_pkg::out_item_t
//   cfg_     write      cfg_wr_en            cfg_wr_data (protocol mode)
//
// one request is decided in the cycle it is accepted and its 0 to 3 results enter a
// four-entry queue; results leave one per cycle while out_stall is low, from the cycle after acceptance.
// a request giving one result sustains one request per cycle while out_stall is low; a request
// with more results is paced by the single result port.
// in_stall rises when the queue cannot take three more results; it never looks at out_stall.
// synchronous active-low reset: header pending, queue empty, protocol mode 1.
module gemini_response_header_parser #(
  parameter int META_LIMIT = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gmhp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gmhp_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  logic                                   mode_r;
  logic                                   in_accept;
  logic                                   room;
  gmhp_pkg::out_item_t [gmhp_pkg::MAX_RES-1:0] res;
  logic [1:0]                             res_n;

  assign in_stall  = !room;
  assign in_accept = in_valid && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  gmhp_parse #(
    .META_LIMIT (META_LIMIT)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_item (in_data),
    .mode    (mode_r),
    .res     (res),
    .res_n   (res_n)
  );

  gmhp_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_data (res),
    .push_n    (in_accept ? res_n : 2'd0),
    .pop       (!out_stall),
    .head      (out_data),
    .not_empty (out_valid),
    .room      (room)
  );

endmodule

FILE: sv/gmhp_parse.sv
// gmhp_parse: header parse state and the per-byte decision, giving up to three results
// per accepted request. Depends on gmhp_pkg.
module gmhp_parse #(
  parameter int META_LIMIT = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   accept,
  input  gmhp_pkg::in_item_t                     in_item,
  input  logic                                   mode,
  output gmhp_pkg::out_item_t [gmhp_pkg::MAX_RES-1:0] res,
  output logic [1:0]                             res_n
);

  localparam logic [gmhp_pkg::HDR_CNT_W-1:0] END_LIMIT =
    gmhp_pkg::HDR_CNT_W'(META_LIMIT + 3);
  localparam logic [gmhp_pkg::HDR_CNT_W-1:0] FAIL_LIMIT =
    gmhp_pkg::HDR_CNT_W'(META_LIMIT + 5);

  gmhp_pkg::phase_t                   phase_r, phase_nxt;
  logic [gmhp_pkg::HDR_CNT_W-1:0]     count_r, count_nxt;
  logic                               cr_held_r, cr_held_nxt;
  logic                               bad_r, bad_nxt;
  logic [3:0]                         first_r, first_nxt;
  logic [3:0]                         second_r, second_nxt;

  gmhp_pkg::out_item_t [gmhp_pkg::MAX_RES-1:0] cand;
  logic [gmhp_pkg::MAX_RES-1:0]       cand_en;
  logic [gmhp_pkg::HDR_CNT_W-1:0]     count_inc;
  logic [gmhp_pkg::HDR_CNT_W-1:0]     hdr_pos;
  logic [7:0]                         b;
  logic                               is_digit;

  assign b         = in_item.data_byte;
  assign is_digit  = (b >= gmhp_pkg::CHAR_ZERO) && (b <= gmhp_pkg::CHAR_NINE);
  assign count_inc = (count_r == gmhp_pkg::HDR_CNT_MAX) ? count_r : count_r + 11'd1;
  // position of the held cr
  assign hdr_pos   = count_r - 11'd1;

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    cr_held_nxt = cr_held_r;
    bad_nxt     = bad_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    cand        = '0;
    cand_en     = '0;
    if (in_item.operation == gmhp_pkg::OP_CLOSE) begin
      if (phase_r != gmhp_pkg::PH_DONE) begin
        if (phase_r == gmhp_pkg::PH_PENDING && mode) begin
          cr_held_nxt = 1'b0;
          cand_en[0]  = 1'b1;
          cand[0]     = gmhp_pkg::mk_fail(gmhp_pkg::ERR_CLOSED);
        end
        cand_en[1]             = 1'b1;
        cand[1].result_kind    = gmhp_pkg::KIND_FINISH;
        phase_nxt              = gmhp_pkg::PH_DONE;
      end
    end else if (phase_r == gmhp_pkg::PH_BODY ||
                 (phase_r == gmhp_pkg::PH_PENDING && !mode)) begin
      cand_en[0] = 1'b1;
      cand[0]    = gmhp_pkg::mk_byte(gmhp_pkg::KIND_BODY, b);
    end else if (phase_r == gmhp_pkg::PH_PENDING) begin
      if (cr_held_r && b == gmhp_pkg::CHAR_LF) begin
        cr_held_nxt = 1'b0;
        cand_en[0]  = 1'b1;
        if (hdr_pos < gmhp_pkg::HDR_MIN_POS || hdr_pos >= END_LIMIT || bad_r) begin
          cand[0]   = gmhp_pkg::mk_fail(gmhp_pkg::ERR_PROTOCOL);
          phase_nxt = gmhp_pkg::PH_FAILED;
        end else begin
          cand[0].result_kind   = gmhp_pkg::KIND_ACCEPT;
          cand[0].status_first  = first_r;
          cand[0].status_second = second_r;
          phase_nxt             = gmhp_pkg::PH_FAILED;
          cand_en[1]            = 1'b1;
          unique case (first_r)
            gmhp_pkg::DIGIT_SUCCESS: begin
              cand_en[1] = 1'b0;
              phase_nxt  = gmhp_pkg::PH_BODY;
            end
            gmhp_pkg::DIGIT_REDIRECT: begin
              cand_en[1] = 1'b0;
              phase_nxt  = gmhp_pkg::PH_REDIRECT;
            end
            gmhp_pkg::DIGIT_TEMP: cand[1] = gmhp_pkg::mk_fail(gmhp_pkg::ERR_UNAVAILABLE);
            gmhp_pkg::DIGIT_PERM: cand[1] = gmhp_pkg::mk_fail(gmhp_pkg::ERR_NOT_FOUND);
            gmhp_pkg::DIGIT_AUTH: cand[1] = gmhp_pkg::mk_fail(gmhp_pkg::ERR_AUTH);
            default:              cand[1] = gmhp_pkg::mk_fail(gmhp_pkg::ERR_UNSUPPORTED);
          endcase
        end
      end else begin
        // a held cr not followed by lf is released as meta text if it lay at position 3 or later
        if (cr_held_r) begin
          cr_held_nxt = 1'b0;
          if (count_r >= gmhp_pkg::HDR_CR_META) begin
            cand_en[0] = 1'b1;
            cand[0]    = gmhp_pkg::mk_byte(gmhp_pkg::KIND_META, gmhp_pkg::CHAR_CR);
          end
        end
        unique case (count_r)
          11'd0: begin
            first_nxt = is_digit ? b[3:0] : 4'd0;
            if (!is_digit) bad_nxt = 1'b1;
          end
          11'd1: begin
            second_nxt = is_digit ? b[3:0] : 4'd0;
            if (!is_digit) bad_nxt = 1'b1;
          end
          11'd2: begin
            if (b != gmhp_pkg::CHAR_SPACE && b != gmhp_pkg::CHAR_TAB) bad_nxt = 1'b1;
          end
          default: ;
        endcase
        count_nxt = count_inc;
        if (b == gmhp_pkg::CHAR_CR) begin
          cr_held_nxt = 1'b1;
        end else if (count_r >= gmhp_pkg::HDR_MIN_POS) begin
          cand_en[1] = 1'b1;
          cand[1]    = gmhp_pkg::mk_byte(gmhp_pkg::KIND_META, b);
        end
        // no crlf within the limit
        if (count_inc >= FAIL_LIMIT) begin
          cr_held_nxt = 1'b0;
          cand_en[2]  = 1'b1;
          cand[2]     = gmhp_pkg::mk_fail(gmhp_pkg::ERR_PROTOCOL);
          phase_nxt   = gmhp_pkg::PH_FAILED;
        end
      end
    end
  end

  // pack the enabled results in order and flag the final one
  always_comb begin
    res   = '0;
    res_n = 2'd0;
    for (int k = 0; k < gmhp_pkg::MAX_RES; k++) begin
      if (cand_en[k]) begin
        res[res_n] = cand[k];
        res_n      = res_n + 2'd1;
      end
    end
    if (res_n != 2'd0) res[res_n - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= gmhp_pkg::PH_PENDING;
      count_r   <= '0;
      cr_held_r <= 1'b0;
      bad_r     <= 1'b0;
      first_r   <= 4'd0;
      second_r  <= 4'd0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      cr_held_r <= cr_held_nxt;
      bad_r     <= bad_nxt;
      first_r   <= first_nxt;
      second_r  <= second_nxt;
    end
  end

endmodule

FILE: sv/gmhp_rq.sv
// gmhp_rq: small result queue, takes up to three results a cycle and hands out one while pop is high.
// Depends on gmhp_pkg.
module gmhp_rq (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  gmhp_pkg::out_item_t [gmhp_pkg::MAX_RES-1:0] push_data,
  input  logic [1:0]                             push_n,
  input  logic                                   pop,
  output gmhp_pkg::out_item_t                    head,
  output logic                                   not_empty,
  output logic                                   room
);

  gmhp_pkg::out_item_t             mem [gmhp_pkg::RQ_DEPTH];
  logic [gmhp_pkg::RQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [gmhp_pkg::RQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [gmhp_pkg::RQ_CNT_W-1:0]   count_r, count_nxt;
  logic                            do_pop;

  assign not_empty = (count_r != '0);
  assign do_pop    = pop && not_empty;
  // room for a full set of results from one request
  assign room      = (count_r <= gmhp_pkg::RQ_CNT_W'(gmhp_pkg::RQ_DEPTH - gmhp_pkg::MAX_RES));
  assign head      = mem[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r + gmhp_pkg::RQ_PTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + gmhp_pkg::RQ_PTR_W'(do_pop);
  assign count_nxt  = count_r + gmhp_pkg::RQ_CNT_W'(push_n)
                      - gmhp_pkg::RQ_CNT_W'(do_pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < gmhp_pkg::MAX_RES; k++) begin
      if (2'(k) < push_n) mem[wr_ptr_r + gmhp_pkg::RQ_PTR_W'(k)] <= push_data[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: sv/gmhp_checker.sv
// gmhp_checker: port-level checks on the response header parser, bound to its top level.
// Depends on gmhp_pkg and gemini_response_header_parser.
module gmhp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input gmhp_pkg::out_item_t out_data
);

  // queue comes out of reset empty and open
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // nothing follows the finished result
  a_finish_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.result_kind == gmhp_pkg::KIND_FINISH
    |-> out_data.last ##1 !out_valid)
    else $error("result after finished");

  // an error status is always followed by its failure
  a_error_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == gmhp_pkg::KIND_ACCEPT &&
    out_data.status_first != gmhp_pkg::DIGIT_SUCCESS &&
    out_data.status_first != gmhp_pkg::DIGIT_REDIRECT
    |-> !out_data.last)
    else $error("error status without failure");

endmodule

bind gemini_response_header_parser gmhp_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
